>>> src/afk_pkg.sv
package afk_pkg;

	// port widths fixed by the field formats
	localparam int ANGLE_W = 16;
	localparam int POS_W   = 16;
	localparam int THR_W   = 15;

	localparam logic [THR_W-1:0] GIMBAL_THRESHOLD_RESET = 15'd32440;

	// geometry and angle constants in Q30
	localparam longint Q30_PI       = 64'sd3373259426;
	localparam longint Q30_TWO_PI   = 64'sd6746518852;
	localparam longint Q30_HALF_PI  = 64'sd1686629713;
	localparam longint Q30_GAIN     = 64'sd652032874;
	localparam longint Q30_OFF_PI   = 64'sd3373256577;
	localparam longint Q30_OFF_HALF = 64'sd1686848406;
	localparam longint Q30_LEN_A    = 64'sd236223201;
	localparam longint Q30_LEN_B    = 64'sd59055800;
	localparam longint Q30_LEN_C    = 64'sd318793948;
	localparam longint Q30_BASE_Z   = 64'sd128849019;

	// arctangent of 2^-i in Q30
	localparam int ATAN_LEN = 24;
	localparam longint ATAN_Q30 [0:ATAN_LEN-1] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
		64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
		64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
		64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768,
		64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048,
		64'sd1024, 64'sd512, 64'sd256, 64'sd128
	};

	// round a Q30 constant to frac fraction bits, half up
	function automatic longint rnd_q30(input longint c, input int frac);
		int s;
		s = 30 - frac;
		if (s <= 0) begin
			return c;
		end
		return (c + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

endpackage

>>> src/arm_forward_kinematics_6dof_unit.sv
// channel    | handshake               | payload
// -----------+-------------------------+-------------------------------------------
// joints in  | start, busy             | base/shoulder/elbow/wrist_turn/
//            |                         | wrist_bend/tool_turn_angle
// pose out   | done (one-cycle strobe) | pos_x, pos_y, pos_z, yaw_out, pitch_out,
//            |                         | roll_out, gimbal_lock
// config     | cfg_valid, cfg_ready    | cfg_data (gimbal threshold)
//
// One joint set is taken every cycle; busy stays low.
// The latency is set by four unrolled CORDIC pipelines in series: joint sin/cos,
// yaw/roll atan2, yaw cos, pitch atan2.
// Reset clears all valid bits and loads the threshold; payload is not reset.
// The receiver cannot stall, so results leave on done with no back pressure.
module arm_forward_kinematics_6dof_unit #(
	parameter int CORDIC_STEPS = 16,
	parameter int WORD_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [afk_pkg::ANGLE_W-1:0] base_angle,
	input  logic signed [afk_pkg::ANGLE_W-1:0] shoulder_angle,
	input  logic signed [afk_pkg::ANGLE_W-1:0] elbow_angle,
	input  logic signed [afk_pkg::ANGLE_W-1:0] wrist_turn_angle,
	input  logic signed [afk_pkg::ANGLE_W-1:0] wrist_bend_angle,
	input  logic signed [afk_pkg::ANGLE_W-1:0] tool_turn_angle,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [afk_pkg::THR_W-1:0]          cfg_data,
	output logic                               done,
	output logic signed [afk_pkg::POS_W-1:0]   pos_x,
	output logic signed [afk_pkg::POS_W-1:0]   pos_y,
	output logic signed [afk_pkg::POS_W-1:0]   pos_z,
	output logic signed [afk_pkg::ANGLE_W-1:0] yaw_out,
	output logic signed [afk_pkg::ANGLE_W-1:0] pitch_out,
	output logic signed [afk_pkg::ANGLE_W-1:0] roll_out,
	output logic                               gimbal_lock
);

	localparam int W    = WORD_BITS + 4;
	localparam int FRAC = WORD_BITS - 2;
	localparam int OW   = W + 16;

	localparam int IN_UP  = (FRAC >= 13) ? FRAC - 13 : 0;
	localparam int IN_DN  = (FRAC < 13) ? 13 - FRAC : 0;
	localparam int O15_UP = (FRAC < 15) ? 15 - FRAC : 0;
	localparam int O15_DN = (FRAC > 15) ? FRAC - 15 : 0;
	localparam int O13_UP = (FRAC < 13) ? 13 - FRAC : 0;
	localparam int O13_DN = (FRAC > 13) ? FRAC - 13 : 0;

	localparam logic signed [W-1:0] HP       = W'(afk_pkg::rnd_q30(afk_pkg::Q30_HALF_PI, FRAC));
	localparam logic signed [W-1:0] OFF_PI   = W'(afk_pkg::rnd_q30(afk_pkg::Q30_OFF_PI, FRAC));
	localparam logic signed [W-1:0] OFF_HALF = W'(afk_pkg::rnd_q30(afk_pkg::Q30_OFF_HALF, FRAC));
	localparam logic signed [W-1:0] LEN_A    = W'(afk_pkg::rnd_q30(afk_pkg::Q30_LEN_A, FRAC));
	localparam logic signed [W-1:0] LEN_B    = W'(afk_pkg::rnd_q30(afk_pkg::Q30_LEN_B, FRAC));
	localparam logic signed [W-1:0] LEN_C    = W'(afk_pkg::rnd_q30(afk_pkg::Q30_LEN_C, FRAC));
	localparam logic signed [W-1:0] BASE_Z   = W'(afk_pkg::rnd_q30(afk_pkg::Q30_BASE_Z, FRAC));

	typedef struct packed {
		logic signed [W-1:0] px, py, pz, r13, r11;
		logic                lock;
	} yside_t;

	typedef struct packed {
		logic signed [W-1:0] px, py, pz, r13, r11, yaw, roll;
		logic                lock;
	} cside_t;

	typedef struct packed {
		logic signed [W-1:0] px, py, pz, yaw, roll;
		logic                lock;
	} pside_t;

	// rounded fixed-point product
	function automatic logic signed [W-1:0] mulf(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [2*W-1:0] pr;
		logic signed [2*W-1:0] half;
		half = '0;
		half[FRAC-1] = 1'b1;
		pr = a * b;
		pr = pr + half;
		return W'(pr >>> FRAC);
	endfunction

	// Q3.13 input to internal format, half is zero when no bits are dropped
	function automatic logic signed [W-1:0] in_angle(input logic signed [15:0] a);
		logic signed [W-1:0] e;
		logic signed [W-1:0] half;
		e = W'(a);
		half = W'((1 << IN_DN) >>> 1);
		return ((e + half) >>> IN_DN) <<< IN_UP;
	endfunction

	// internal format to a saturated 16-bit output
	function automatic logic signed [15:0] out16(input logic signed [W-1:0] v,
			input int up, input int dn);
		logic signed [OW-1:0] e;
		logic signed [OW-1:0] r;
		logic signed [OW-1:0] half;
		e = OW'(v);
		half = '0;
		if (dn > 0) begin
			half[dn-1] = 1'b1;
			r = (e + half) >>> dn;
		end else begin
			r = e <<< up;
		end
		if (r > 32767) begin
			return 16'sh7fff;
		end else if (r < -32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	// configuration register
	logic [afk_pkg::THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= afk_pkg::GIMBAL_THRESHOLD_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// valid bits
	logic v_s0, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, done_q;
	logic sc_v, at_v, cy_v, pt_v;

	// input stage: offsets added
	logic signed [W-1:0] th_s0 [0:5];

	always_ff @(posedge clk) begin
		th_s0[0] <= in_angle(base_angle) + OFF_PI;
		th_s0[1] <= in_angle(shoulder_angle);
		th_s0[2] <= in_angle(elbow_angle) + OFF_HALF;
		th_s0[3] <= in_angle(wrist_turn_angle) + OFF_PI;
		th_s0[4] <= in_angle(wrist_bend_angle);
		th_s0[5] <= in_angle(tool_turn_angle);
	end

	// joint sin/cos pipelines
	logic signed [W-1:0] js [0:5];
	logic signed [W-1:0] jc [0:5];

	for (genvar j = 0; j < 6; j++) begin : g_joint
		if (j == 0) begin : g_lead
			afk_sincos #(.WORD_BITS(WORD_BITS), .CORDIC_STEPS(CORDIC_STEPS), .SIDE_W(1)) u_sc (
				.clk(clk), .arst_n(arst_n), .in_valid(v_s0), .theta(th_s0[j]),
				.in_side(1'b0), .out_valid(sc_v), .sin_val(js[j]), .cos_val(jc[j]),
				.out_side()
			);
		end else begin : g_rest
			afk_sincos #(.WORD_BITS(WORD_BITS), .CORDIC_STEPS(CORDIC_STEPS), .SIDE_W(1)) u_sc (
				.clk(clk), .arst_n(arst_n), .in_valid(v_s0), .theta(th_s0[j]),
				.in_side(1'b0), .out_valid(), .sin_val(js[j]), .cos_val(jc[j]),
				.out_side()
			);
		end
	end

	// stage 1: joint products
	logic signed [W-1:0] c2s3_s1, s2c3_s1, c2c3_s1, s2s3_s1, c4c5_s1, s4s6_s1, c6s4_s1;
	logic signed [W-1:0] c4s5_s1, s1s4_s1, c4s1_s1, c1c4_s1, c1s4_s1;
	logic signed [W-1:0] c1_s1, s1_s1, c2_s1, s2_s1, c4_s1, s4_s1, c5_s1, s5_s1, c6_s1, s6_s1;

	always_ff @(posedge clk) begin
		c2s3_s1 <= mulf(jc[1], js[2]);
		s2c3_s1 <= mulf(jc[2], js[1]);
		c2c3_s1 <= mulf(jc[1], jc[2]);
		s2s3_s1 <= mulf(js[1], js[2]);
		c4c5_s1 <= mulf(jc[3], jc[4]);
		s4s6_s1 <= mulf(js[3], js[5]);
		c6s4_s1 <= mulf(jc[5], js[3]);
		c4s5_s1 <= mulf(jc[3], js[4]);
		s1s4_s1 <= mulf(js[0], js[3]);
		c4s1_s1 <= mulf(jc[3], js[0]);
		c1c4_s1 <= mulf(jc[0], jc[3]);
		c1s4_s1 <= mulf(jc[0], js[3]);
		c1_s1 <= jc[0]; s1_s1 <= js[0];
		c2_s1 <= jc[1]; s2_s1 <= js[1];
		c4_s1 <= jc[3]; s4_s1 <= js[3];
		c5_s1 <= jc[4]; s5_s1 <= js[4];
		c6_s1 <= jc[5]; s6_s1 <= js[5];
	end

	// stage 2: shoulder-elbow sums
	logic signed [W-1:0] a_s2, b_s2, u_s2, v_s2_val;
	logic signed [W-1:0] c1_s2, s1_s2, c2_s2, s2_s2, c4_s2, s4_s2, c5_s2, s5_s2, c6_s2, s6_s2;
	logic signed [W-1:0] c4c5_s2, s4s6_s2, c6s4_s2, c4s5_s2, s1s4_s2, c4s1_s2, c1c4_s2, c1s4_s2;

	always_ff @(posedge clk) begin
		a_s2     <= c2s3_s1 + s2c3_s1;
		b_s2     <= c2c3_s1 - s2s3_s1;
		u_s2     <= c2c3_s1 + s2s3_s1;
		v_s2_val <= s2c3_s1 - c2s3_s1;
		c1_s2 <= c1_s1; s1_s2 <= s1_s1; c2_s2 <= c2_s1; s2_s2 <= s2_s1;
		c4_s2 <= c4_s1; s4_s2 <= s4_s1; c5_s2 <= c5_s1; s5_s2 <= s5_s1;
		c6_s2 <= c6_s1; s6_s2 <= s6_s1;
		c4c5_s2 <= c4c5_s1; s4s6_s2 <= s4s6_s1; c6s4_s2 <= c6s4_s1; c4s5_s2 <= c4s5_s1;
		s1s4_s2 <= s1s4_s1; c4s1_s2 <= c4s1_s1; c1c4_s2 <= c1c4_s1; c1s4_s2 <= c1s4_s1;
	end

	// stage 3: link lengths and base rotation products
	logic signed [W-1:0] lac2_s3, lbu_s3, lcv_s3, las2_s3, lba_s3, lcb_s3;
	logic signed [W-1:0] c1a_s3, c1b_s3, s1a_s3, s1b_s3, s5b_s3, c4c5a_s3;
	logic signed [W-1:0] s4s6a_s3, c6s4a_s3, c4s5a_s3, c5b_s3;
	logic signed [W-1:0] c1_s3, s1_s3, c4_s3, s4_s3, c5_s3, s5_s3, c6_s3, s6_s3;
	logic signed [W-1:0] s1s4_s3, c4s1_s3, c1c4_s3, c1s4_s3;

	always_ff @(posedge clk) begin
		lac2_s3  <= mulf(LEN_A, c2_s2);
		lbu_s3   <= mulf(LEN_B, u_s2);
		lcv_s3   <= mulf(LEN_C, v_s2_val);
		las2_s3  <= mulf(LEN_A, s2_s2);
		lba_s3   <= mulf(LEN_B, a_s2);
		lcb_s3   <= mulf(LEN_C, b_s2);
		c1a_s3   <= mulf(c1_s2, a_s2);
		c1b_s3   <= mulf(c1_s2, b_s2);
		s1a_s3   <= mulf(s1_s2, a_s2);
		s1b_s3   <= mulf(s1_s2, b_s2);
		s5b_s3   <= mulf(s5_s2, b_s2);
		c4c5a_s3 <= mulf(c4c5_s2, a_s2);
		s4s6a_s3 <= mulf(s4s6_s2, a_s2);
		c6s4a_s3 <= mulf(c6s4_s2, a_s2);
		c4s5a_s3 <= mulf(c4s5_s2, a_s2);
		c5b_s3   <= mulf(c5_s2, b_s2);
		c1_s3 <= c1_s2; s1_s3 <= s1_s2; c4_s3 <= c4_s2; s4_s3 <= s4_s2;
		c5_s3 <= c5_s2; s5_s3 <= s5_s2; c6_s3 <= c6_s2; s6_s3 <= s6_s2;
		s1s4_s3 <= s1s4_s2; c4s1_s3 <= c4s1_s2; c1c4_s3 <= c1c4_s2; c1s4_s3 <= c1s4_s2;
	end

	// stage 4: reach and height, wrist products
	logic signed [W-1:0] p_reach_s4, pz_s4, t_s4, r33_s4;
	logic signed [W-1:0] c4c1b_s4, s4c1b_s4, s4s1b_s4, c4s1b_s4;
	logic signed [W-1:0] c1_s4, s1_s4, c5_s4, s5_s4, c6_s4, s6_s4;
	logic signed [W-1:0] s1s4_s4, c4s1_s4, c1c4_s4, c1s4_s4, c1a_s4, s1a_s4, s4s6a_s4, c6s4a_s4;

	always_ff @(posedge clk) begin
		p_reach_s4 <= lac2_s3 + lbu_s3 + lcv_s3;
		pz_s4      <= las2_s3 + lba_s3 + lcb_s3 + BASE_Z;
		t_s4       <= -s5b_s3 - c4c5a_s3;
		r33_s4     <= c5b_s3 - c4s5a_s3;
		c4c1b_s4   <= mulf(c4_s3, c1b_s3);
		s4c1b_s4   <= mulf(s4_s3, c1b_s3);
		s4s1b_s4   <= mulf(s4_s3, s1b_s3);
		c4s1b_s4   <= mulf(c4_s3, s1b_s3);
		c1_s4 <= c1_s3; s1_s4 <= s1_s3; c5_s4 <= c5_s3; s5_s4 <= s5_s3;
		c6_s4 <= c6_s3; s6_s4 <= s6_s3;
		s1s4_s4 <= s1s4_s3; c4s1_s4 <= c4s1_s3; c1c4_s4 <= c1c4_s3; c1s4_s4 <= c1s4_s3;
		c1a_s4 <= c1a_s3; s1a_s4 <= s1a_s3; s4s6a_s4 <= s4s6a_s3; c6s4a_s4 <= c6s4a_s3;
	end

	// stage 5: x/y position, wrist terms
	logic signed [W-1:0] px_s5, py_s5, p_s5, r_s5, m_s5, n_s5, c6t_s5, s6t_s5;
	logic signed [W-1:0] pz_s5, r33_s5, c5_s5, s5_s5, c6_s5, s6_s5;
	logic signed [W-1:0] c1a_s5, s1a_s5, s4s6a_s5, c6s4a_s5;

	always_ff @(posedge clk) begin
		px_s5  <= mulf(c1_s4, p_reach_s4);
		py_s5  <= mulf(s1_s4, p_reach_s4);
		p_s5   <= s1s4_s4 - c4c1b_s4;
		r_s5   <= c4s1_s4 + s4c1b_s4;
		m_s5   <= s4s1b_s4 - c1c4_s4;
		n_s5   <= c1s4_s4 + c4s1b_s4;
		c6t_s5 <= mulf(c6_s4, t_s4);
		s6t_s5 <= mulf(s6_s4, t_s4);
		pz_s5 <= pz_s4; r33_s5 <= r33_s4; c5_s5 <= c5_s4; s5_s5 <= s5_s4;
		c6_s5 <= c6_s4; s6_s5 <= s6_s4;
		c1a_s5 <= c1a_s4; s1a_s5 <= s1a_s4; s4s6a_s5 <= s4s6a_s4; c6s4a_s5 <= c6s4a_s4;
	end

	// stage 6: joint-5 products, third row entries
	logic signed [W-1:0] s5c1a_s6, c5p_s6, s5p_s6, c5c1a_s6, s5s1a_s6, c5n_s6, s5n_s6, c5s1a_s6;
	logic signed [W-1:0] r31_s6, r32_s6, px_s6, py_s6, pz_s6, r33_s6, c6_s6, s6_s6, r_s6, m_s6;

	always_ff @(posedge clk) begin
		s5c1a_s6 <= mulf(s5_s5, c1a_s5);
		c5p_s6   <= mulf(c5_s5, p_s5);
		s5p_s6   <= mulf(s5_s5, p_s5);
		c5c1a_s6 <= mulf(c5_s5, c1a_s5);
		s5s1a_s6 <= mulf(s5_s5, s1a_s5);
		c5n_s6   <= mulf(c5_s5, n_s5);
		s5n_s6   <= mulf(s5_s5, n_s5);
		c5s1a_s6 <= mulf(c5_s5, s1a_s5);
		r31_s6   <= -c6t_s5 - s4s6a_s5;
		r32_s6   <= s6t_s5 - c6s4a_s5;
		px_s6 <= px_s5; py_s6 <= py_s5; pz_s6 <= pz_s5; r33_s6 <= r33_s5;
		c6_s6 <= c6_s5; s6_s6 <= s6_s5; r_s6 <= r_s5; m_s6 <= m_s5;
	end

	// stage 7: q, w, R13, R23
	logic signed [W-1:0] q_s7, w_s7, r13_s7, r23_s7;
	logic signed [W-1:0] px_s7, py_s7, pz_s7, r31_s7, r32_s7, r33_s7, c6_s7, s6_s7, r_s7, m_s7;

	always_ff @(posedge clk) begin
		q_s7   <= s5c1a_s6 + c5p_s6;
		w_s7   <= s5s1a_s6 - c5n_s6;
		r13_s7 <= s5p_s6 - c5c1a_s6;
		r23_s7 <= -s5n_s6 - c5s1a_s6;
		px_s7 <= px_s6; py_s7 <= py_s6; pz_s7 <= pz_s6;
		r31_s7 <= r31_s6; r32_s7 <= r32_s6; r33_s7 <= r33_s6;
		c6_s7 <= c6_s6; s6_s7 <= s6_s6; r_s7 <= r_s6; m_s7 <= m_s6;
	end

	// stage 8: joint-6 products
	logic signed [W-1:0] c6q_s8, s6r_s8, s6q_s8, c6r_s8, s6m_s8, c6w_s8, s6w_s8, c6m_s8;
	logic signed [W-1:0] px_s8, py_s8, pz_s8, r13_s8, r23_s8, r31_s8, r32_s8, r33_s8;

	always_ff @(posedge clk) begin
		c6q_s8 <= mulf(c6_s7, q_s7);
		s6r_s8 <= mulf(s6_s7, r_s7);
		s6q_s8 <= mulf(s6_s7, q_s7);
		c6r_s8 <= mulf(c6_s7, r_s7);
		s6m_s8 <= mulf(s6_s7, m_s7);
		c6w_s8 <= mulf(c6_s7, w_s7);
		s6w_s8 <= mulf(s6_s7, w_s7);
		c6m_s8 <= mulf(c6_s7, m_s7);
		px_s8 <= px_s7; py_s8 <= py_s7; pz_s8 <= pz_s7;
		r13_s8 <= r13_s7; r23_s8 <= r23_s7;
		r31_s8 <= r31_s7; r32_s8 <= r32_s7; r33_s8 <= r33_s7;
	end

	// stage 9: first two rows
	logic signed [W-1:0] r11_s9, r12_s9, r21_s9, r22_s9;
	logic signed [W-1:0] px_s9, py_s9, pz_s9, r13_s9, r23_s9, r31_s9, r32_s9, r33_s9;

	always_ff @(posedge clk) begin
		r11_s9 <= -c6q_s8 - s6r_s8;
		r12_s9 <= s6q_s8 - c6r_s8;
		r21_s9 <= -s6m_s8 - c6w_s8;
		r22_s9 <= s6w_s8 - c6m_s8;
		px_s9 <= px_s8; py_s9 <= py_s8; pz_s9 <= pz_s8;
		r13_s9 <= r13_s8; r23_s9 <= r23_s8;
		r31_s9 <= r31_s8; r32_s9 <= r32_s8; r33_s9 <= r33_s8;
	end

	// stage 10: gimbal-lock test and atan2 operand choice
	logic [W-1:0]      abs13;
	logic [W+14:0]     lock_lhs, lock_rhs;
	logic              lock_now;

	always_comb begin
		abs13    = (r13_s9 < 0) ? $unsigned(-r13_s9) : $unsigned(r13_s9);
		lock_lhs = {abs13, 15'd0};
		lock_rhs = (W + 15)'(thr_q) << FRAC;
		lock_now = lock_lhs > lock_rhs;
	end

	logic signed [W-1:0] ry_s10, rx_s10;
	logic                rneg_s10;
	yside_t              yside_s10;
	logic signed [W-1:0] yy_s10, yx_s10;

	always_ff @(posedge clk) begin
		yy_s10 <= r12_s9;
		yx_s10 <= r11_s9;
		if (lock_now) begin
			if (r13_s9 > 0) begin
				ry_s10   <= r32_s9;
				rx_s10   <= r22_s9;
				rneg_s10 <= 1'b0;
			end else begin
				ry_s10   <= r21_s9;
				rx_s10   <= r31_s9;
				rneg_s10 <= 1'b1;
			end
		end else begin
			ry_s10   <= r23_s9;
			rx_s10   <= r33_s9;
			rneg_s10 <= 1'b1;
		end
		yside_s10.px   <= px_s9;
		yside_s10.py   <= py_s9;
		yside_s10.pz   <= pz_s9;
		yside_s10.r13  <= r13_s9;
		yside_s10.r11  <= r11_s9;
		yside_s10.lock <= lock_now;
	end

	// yaw and roll atan2
	logic signed [W-1:0] yaw_z, roll_z;
	yside_t              yside_at;
	logic                rneg_at;

	afk_atan2 #(.WORD_BITS(WORD_BITS), .CORDIC_STEPS(CORDIC_STEPS),
			.SIDE_W($bits(yside_t))) u_at_yaw (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s10), .y_in(yy_s10), .x_in(yx_s10),
		.in_side(yside_s10), .out_valid(at_v), .angle(yaw_z), .out_side(yside_at)
	);

	afk_atan2 #(.WORD_BITS(WORD_BITS), .CORDIC_STEPS(CORDIC_STEPS), .SIDE_W(1)) u_at_roll (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s10), .y_in(ry_s10), .x_in(rx_s10),
		.in_side(rneg_s10), .out_valid(), .angle(roll_z), .out_side(rneg_at)
	);

	// stage 11: signs of yaw and roll
	logic signed [W-1:0] yaw_s11;
	cside_t              cside_s11;

	always_ff @(posedge clk) begin
		yaw_s11        <= -yaw_z;
		cside_s11.px   <= yside_at.px;
		cside_s11.py   <= yside_at.py;
		cside_s11.pz   <= yside_at.pz;
		cside_s11.r13  <= yside_at.r13;
		cside_s11.r11  <= yside_at.r11;
		cside_s11.yaw  <= -yaw_z;
		cside_s11.roll <= rneg_at ? -roll_z : roll_z;
		cside_s11.lock <= yside_at.lock;
	end

	// cosine of yaw
	logic signed [W-1:0] yaw_cos;
	cside_t              cside_sc;

	afk_sincos #(.WORD_BITS(WORD_BITS), .CORDIC_STEPS(CORDIC_STEPS),
			.SIDE_W($bits(cside_t))) u_sc_yaw (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s11), .theta(yaw_s11),
		.in_side(cside_s11), .out_valid(cy_v), .sin_val(), .cos_val(yaw_cos),
		.out_side(cside_sc)
	);

	// stage 12: pitch numerator
	logic signed [W-1:0] num_s12, r11_s12;
	pside_t              pside_s12;

	always_ff @(posedge clk) begin
		num_s12        <= mulf(cside_sc.r13, yaw_cos);
		r11_s12        <= cside_sc.r11;
		pside_s12.px   <= cside_sc.px;
		pside_s12.py   <= cside_sc.py;
		pside_s12.pz   <= cside_sc.pz;
		pside_s12.yaw  <= cside_sc.yaw;
		pside_s12.roll <= cside_sc.roll;
		pside_s12.lock <= cside_sc.lock;
	end

	// stage 13: fold the sign of R11 into the numerator
	logic signed [W-1:0] num_s13, den_s13;
	pside_t              pside_s13;

	always_ff @(posedge clk) begin
		if (r11_s12 < 0) begin
			num_s13 <= -num_s12;
			den_s13 <= -r11_s12;
		end else begin
			num_s13 <= num_s12;
			den_s13 <= r11_s12;
		end
		pside_s13 <= pside_s12;
	end

	// pitch atan2
	logic signed [W-1:0] pitch_z;
	pside_t              pside_at;

	afk_atan2 #(.WORD_BITS(WORD_BITS), .CORDIC_STEPS(CORDIC_STEPS),
			.SIDE_W($bits(pside_t))) u_at_pitch (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s13), .y_in(num_s13), .x_in(den_s13),
		.in_side(pside_s13), .out_valid(pt_v), .angle(pitch_z), .out_side(pside_at)
	);

	// output registers with branch select and saturation
	logic signed [15:0] pos_x_q, pos_y_q, pos_z_q, yaw_q, pitch_q, roll_q;
	logic               lock_q;

	always_ff @(posedge clk) begin
		pos_x_q <= out16(pside_at.px, O15_UP, O15_DN);
		pos_y_q <= out16(pside_at.py, O15_UP, O15_DN);
		pos_z_q <= out16(pside_at.pz, O15_UP, O15_DN);
		yaw_q   <= pside_at.lock ? 16'sd0 : out16(pside_at.yaw, O13_UP, O13_DN);
		pitch_q <= out16(pside_at.lock ? HP : pitch_z, O13_UP, O13_DN);
		roll_q  <= out16(pside_at.roll, O13_UP, O13_DN);
		lock_q  <= pside_at.lock;
	end

	// valid chain through the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0   <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			v_s10  <= 1'b0;
			v_s11  <= 1'b0;
			v_s12  <= 1'b0;
			v_s13  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s0   <= start && !busy;
			v_s1   <= sc_v;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			v_s10  <= v_s9;
			v_s11  <= at_v;
			v_s12  <= cy_v;
			v_s13  <= v_s12;
			done_q <= pt_v;
		end
	end

	assign done        = done_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign pos_z       = pos_z_q;
	assign yaw_out     = yaw_q;
	assign pitch_out   = pitch_q;
	assign roll_out    = roll_q;
	assign gimbal_lock = lock_q;

endmodule

>>> src/afk_sincos.sv
module afk_sincos #(
	parameter int WORD_BITS    = 16,
	parameter int CORDIC_STEPS = 16,
	parameter int SIDE_W       = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [WORD_BITS+3:0] theta,
	input  logic [SIDE_W-1:0]         in_side,
	output logic                      out_valid,
	output logic signed [WORD_BITS+3:0] sin_val,
	output logic signed [WORD_BITS+3:0] cos_val,
	output logic [SIDE_W-1:0]         out_side
);

	localparam int W    = WORD_BITS + 4;
	localparam int FRAC = WORD_BITS - 2;
	localparam int S    = CORDIC_STEPS;

	localparam logic signed [W-1:0] PI   = W'(afk_pkg::rnd_q30(afk_pkg::Q30_PI, FRAC));
	localparam logic signed [W-1:0] TP   = W'(afk_pkg::rnd_q30(afk_pkg::Q30_TWO_PI, FRAC));
	localparam logic signed [W-1:0] HP   = W'(afk_pkg::rnd_q30(afk_pkg::Q30_HALF_PI, FRAC));
	localparam logic signed [W-1:0] GAIN = W'(afk_pkg::rnd_q30(afk_pkg::Q30_GAIN, FRAC));

	// stage 0 wrap, stage 1 fold, then one stage per rotation, then sign fix
	logic                v_s    [0:S+2];
	logic [SIDE_W-1:0]   side_s [0:S+2];
	logic signed [W-1:0] wrap_s;
	logic signed [W-1:0] x_s    [0:S];
	logic signed [W-1:0] y_s    [0:S];
	logic signed [W-1:0] z_s    [0:S];
	logic                neg_s  [0:S];
	logic signed [W-1:0] sin_q, cos_q;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= S + 2; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			v_s[0] <= in_valid;
			for (int k = 0; k < S + 2; k++) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	// sideband chain
	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int k = 0; k < S + 2; k++) begin
			side_s[k+1] <= side_s[k];
		end
	end

	// wrap into [-pi, pi]
	always_ff @(posedge clk) begin
		if (theta > PI) begin
			wrap_s <= theta - TP;
		end else if (theta < -PI) begin
			wrap_s <= theta + TP;
		end else begin
			wrap_s <= theta;
		end
	end

	// fold into [-pi/2, pi/2] and seed the rotation
	always_ff @(posedge clk) begin
		x_s[0] <= GAIN;
		y_s[0] <= '0;
		if (wrap_s > HP) begin
			z_s[0]   <= wrap_s - PI;
			neg_s[0] <= 1'b1;
		end else if (wrap_s < -HP) begin
			z_s[0]   <= wrap_s + PI;
			neg_s[0] <= 1'b1;
		end else begin
			z_s[0]   <= wrap_s;
			neg_s[0] <= 1'b0;
		end
	end

	// rotation stages
	for (genvar i = 0; i < S; i++) begin : g_step
		localparam logic signed [W-1:0] K = W'(afk_pkg::rnd_q30(afk_pkg::ATAN_Q30[i], FRAC));
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - K;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + K;
			end
		end
	end

	// undo the fold
	always_ff @(posedge clk) begin
		if (neg_s[S]) begin
			cos_q <= -x_s[S];
			sin_q <= -y_s[S];
		end else begin
			cos_q <= x_s[S];
			sin_q <= y_s[S];
		end
	end

	assign out_valid = v_s[S+2];
	assign out_side  = side_s[S+2];
	assign sin_val   = sin_q;
	assign cos_val   = cos_q;

endmodule

>>> src/afk_atan2.sv
module afk_atan2 #(
	parameter int WORD_BITS    = 16,
	parameter int CORDIC_STEPS = 16,
	parameter int SIDE_W       = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic signed [WORD_BITS+3:0] y_in,
	input  logic signed [WORD_BITS+3:0] x_in,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic signed [WORD_BITS+3:0] angle,
	output logic [SIDE_W-1:0]           out_side
);

	localparam int W    = WORD_BITS + 4;
	localparam int FRAC = WORD_BITS - 2;
	localparam int S    = CORDIC_STEPS;

	localparam logic signed [W-1:0] HP = W'(afk_pkg::rnd_q30(afk_pkg::Q30_HALF_PI, FRAC));

	// stage 0 quadrant fix, then one stage per vectoring step
	logic                v_s    [0:S];
	logic [SIDE_W-1:0]   side_s [0:S];
	logic                zero_s [0:S];
	logic signed [W-1:0] x_s    [0:S];
	logic signed [W-1:0] y_s    [0:S];
	logic signed [W-1:0] z_s    [0:S];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= S; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			v_s[0] <= in_valid;
			for (int k = 0; k < S; k++) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	// sideband and zero-vector flag
	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		for (int k = 0; k < S; k++) begin
			side_s[k+1] <= side_s[k];
			zero_s[k+1] <= zero_s[k];
		end
	end

	// left half plane turned by a quarter
	always_ff @(posedge clk) begin
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x_s[0] <= y_in;
				y_s[0] <= -x_in;
				z_s[0] <= HP;
			end else begin
				x_s[0] <= -y_in;
				y_s[0] <= x_in;
				z_s[0] <= -HP;
			end
		end else begin
			x_s[0] <= x_in;
			y_s[0] <= y_in;
			z_s[0] <= '0;
		end
	end

	// vectoring stages
	for (genvar i = 0; i < S; i++) begin : g_step
		localparam logic signed [W-1:0] K = W'(afk_pkg::rnd_q30(afk_pkg::ATAN_Q30[i], FRAC));
		always_ff @(posedge clk) begin
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + K;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - K;
			end
		end
	end

	assign out_valid = v_s[S];
	assign out_side  = side_s[S];
	assign angle     = zero_s[S] ? '0 : z_s[S];

endmodule
